/* rtl/bbe_pkg.sv */
// Shared types and codes for the B-spline basis evaluator.
// Used by bspline_basis_eval; depends on nothing else.
`default_nettype none
package bbe_pkg;
   // Width of a knot position (basis index plus triangle offsets).
   localparam int PosW = 9;
   typedef logic [PosW-1:0] pos_type;
   typedef logic signed [31:0] knot_type;

   // Request kinds carried in req_tuser.
   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_EVAL = 1'b1;

   // Configuration register indexes.
   localparam logic CFG_DEGREE     = 1'b0;
   localparam logic CFG_LAST_INDEX = 1'b1;

   // Result status codes.
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_INDEX  = 2'd1;
   localparam logic [1:0] ST_DEGREE = 2'd2;
endpackage
`default_nettype wire

/* rtl/bbe_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Holds the knot table; no dependencies.
`default_nettype none
module bbe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

/* rtl/bbe_div.sv */
// Restoring signed divider, one quotient bit per cycle, truncating toward zero.
// Shared by every term of the basis triangle; no dependencies.
`default_nettype none
module bbe_div #(
   parameter int NW = 51,
   parameter int DW = 33
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic signed [NW-1:0] num,
   input  wire logic signed [DW-1:0] den,
   output logic                      done,
   output logic signed [NW-1:0]      quot
);
   localparam int CW = $clog2(NW + 1);

   logic [NW-1:0] a_ff, a_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] dm_ff, dm_in;
   logic          neg_ff, neg_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [DW:0]   sh;
   logic [DW:0]   diff;

   // One shift-and-subtract step per cycle.
   always_comb begin
      a_in    = a_ff;
      rem_in  = rem_ff;
      dm_in   = dm_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      sh      = {rem_ff, a_ff[NW-1]};
      diff    = sh - {1'b0, dm_ff};
      if (start) begin
         a_in    = num[NW-1] ? NW'(-num) : NW'(num);
         dm_in   = den[DW-1] ? DW'(-den) : DW'(den);
         neg_in  = num[NW-1] ^ den[DW-1];
         rem_in  = '0;
         cnt_in  = CW'(NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (sh >= {1'b0, dm_ff}) begin
            rem_in = diff[DW-1:0];
            a_in   = {a_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = sh[DW-1:0];
            a_in   = {a_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      a_ff   <= a_in;
      rem_ff <= rem_in;
      dm_ff  <= dm_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign quot = neg_ff ? -$signed(a_ff) : $signed(a_ff);
endmodule
`default_nettype wire

/* rtl/bspline_basis_eval.sv */
// B-spline basis evaluator (Cox-de Boor triangle), top level.
// Uses bbe_pkg, bbe_ram for the knot table and bbe_div as the shared divider.
//
// Usage: req_tuser selects the beat kind. A load beat writes knot_value into
// slot knot_slot of the knot table. An evaluate beat gives basis_index and
// x_value and produces one rsp beat with basis_value (Q1.F) and status. Load
// beats produce no response. Registers degree and last_control_index are
// written through csr_we/csr_index/csr_wdata; the user must write them only
// while idle, as the block itself does not enforce it. An evaluate that fails
// its checks goes from idle straight to its result. Otherwise level 0 reads
// the knots of each position and sets its indicator value, every triangle
// entry (a pair of weighted terms) runs the serial divider once per term,
// skipped for a term whose knot span is zero, and every unused position is
// passed over in a single sequencer step. One item is in work at a time;
// req_tready is high only while the sequencer is idle. The result waits in an
// output register; if rsp_tready is low, the next evaluate holds its result
// until the previous beat is taken.
// Synchronous reset clears control state and sets degree and
// last_control_index to 1; knot contents are undefined until written.
`default_nettype none
module bspline_basis_eval #(
   parameter int MAX_DEGREE = 3,
   parameter int KNOT_DEPTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Request channel.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // tdata: knot_slot[4:0], knot_value[36:5], basis_index[41:37], x_value[73:42]
   input  wire logic [79:0] req_tdata,
   // tuser: req_type
   input  wire logic        req_tuser,
   // Response channel.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // tdata: basis_value[FRAC_BITS:0], status[FRAC_BITS+2:FRAC_BITS+1]
   output logic [((FRAC_BITS+3+7)/8)*8-1:0] rsp_tdata,
   // Configuration write port.
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [4:0]  csr_wdata
);
   import bbe_pkg::*;

   localparam int L    = MAX_DEGREE + 1;
   localparam int JW   = $clog2(L);
   localparam int AW   = $clog2(KNOT_DEPTH);
   localparam int VW   = FRAC_BITS + 1;
   localparam int PRW  = 33 + VW + 1;
   localparam int RSPW = ((FRAC_BITS + 3 + 7) / 8) * 8;
   localparam logic [VW-1:0] One = VW'(1) << FRAC_BITS;
   localparam logic [2:0] MaxDeg = 3'(MAX_DEGREE);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_STEP = 4'd1;
   localparam logic [3:0] S_READ = 4'd2;
   localparam logic [3:0] S_LV0  = 4'd3;
   localparam logic [3:0] S_MUL  = 4'd4;
   localparam logic [3:0] S_DIV  = 4'd5;
   localparam logic [3:0] S_SUM  = 4'd6;
   localparam logic [3:0] S_DONE = 4'd7;

   // Request fields.
   logic [4:0]  f_slot;
   knot_type    f_knot;
   logic [4:0]  f_index;
   knot_type    f_x;
   assign f_slot  = req_tdata[4:0];
   assign f_knot  = req_tdata[36:5];
   assign f_index = req_tdata[41:37];
   assign f_x     = req_tdata[73:42];

   // Configuration registers.
   logic [1:0] degree_ff;
   logic [4:0] lci_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         degree_ff <= 2'd1;
         lci_ff    <= 5'd1;
      end else if (csr_we) begin
         unique case (csr_index)
            CFG_DEGREE:     degree_ff <= csr_wdata[1:0];
            CFG_LAST_INDEX: lci_ff    <= csr_wdata;
            default:        ;
         endcase
      end
   end

   // Sequencer and datapath state.
   logic [3:0]          state_ff, state_in;
   logic [4:0]          idx_ff, idx_in;
   knot_type            x_ff, x_in;
   logic [1:0]          p_ff, p_in;
   logic [1:0]          q_ff, q_in;
   logic [JW-1:0]       j_ff, j_in;
   logic [2:0]          rc_ff, rc_in;
   logic                ph_ff, ph_in;
   logic                started_ff, started_in;
   logic                ok_ff;
   knot_type            kr_ff [4];
   knot_type            kr_in [4];
   logic [VW-1:0]       lv_ff [L];
   logic [VW-1:0]       lv_in [L];
   logic signed [PRW-1:0] prod_ff, prod_in;
   logic signed [32:0]    den_ff, den_in;
   logic signed [PRW-1:0] t1_ff, t1_in;
   logic signed [PRW-1:0] t2_ff, t2_in;
   logic [1:0]          status_ff, status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0]       rsp_value_ff, rsp_value_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;

   // Knot table and divider.
   logic                ram_we;
   logic [AW-1:0]       ram_raddr;
   logic [31:0]         ram_rdata;
   pos_type             slot_pos;
   pos_type             k_pos;
   pos_type             rd_pos;
   logic                rd_ok;
   logic                div_start;
   logic                div_done;
   logic signed [PRW-1:0] div_quot;

   assign slot_pos = PosW'(f_slot);
   assign ram_we   = req_tvalid && req_tready && (req_tuser == REQ_LOAD)
                     && (slot_pos < PosW'(KNOT_DEPTH));

   bbe_ram #(.WIDTH(32), .DEPTH(KNOT_DEPTH)) u_knots (
      .clock (clock),
      .we    (ram_we),
      .waddr (slot_pos[AW-1:0]),
      .wdata (f_knot),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   bbe_div #(.NW(PRW), .DW(33)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (prod_ff),
      .den   (den_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   // Knot position for the current read slot.
   assign k_pos = PosW'(idx_ff) + PosW'(j_ff);
   always_comb begin
      if (q_ff == 2'd0) begin
         rd_pos = k_pos + PosW'(rc_ff[0]);
      end else begin
         unique case (rc_ff[1:0])
            2'd0:    rd_pos = k_pos;
            2'd1:    rd_pos = k_pos + PosW'(q_ff);
            2'd2:    rd_pos = k_pos + PosW'(1);
            default: rd_pos = k_pos + PosW'(q_ff) + PosW'(1);
         endcase
      end
   end
   assign rd_ok     = rd_pos < PosW'(KNOT_DEPTH);
   assign ram_raddr = rd_pos[AW-1:0];

   always_ff @(posedge clock) begin
      ok_ff <= rd_ok;
   end

   // Arithmetic helpers for the current step.
   logic signed [32:0]    x_ext;
   logic signed [32:0]    num_sel;
   logic signed [32:0]    den_sel;
   logic [VW-1:0]         low_sel;
   logic signed [PRW:0]   sum;
   logic [VW-1:0]         sat;
   logic                  last_j;
   logic                  is_term;
   logic                  ind;
   logic [2:0]            rc_last;
   logic signed [PRW-1:0] term;

   assign x_ext   = {x_ff[31], x_ff};
   assign num_sel = ph_ff ? ({kr_ff[3][31], kr_ff[3]} - x_ext)
                          : (x_ext - {kr_ff[0][31], kr_ff[0]});
   assign den_sel = ph_ff ? ({kr_ff[3][31], kr_ff[3]} - {kr_ff[2][31], kr_ff[2]})
                          : ({kr_ff[1][31], kr_ff[1]} - {kr_ff[0][31], kr_ff[0]});
   assign low_sel = ph_ff ? lv_ff[1] : lv_ff[0];
   assign sum     = {t1_ff[PRW-1], t1_ff} + {t2_ff[PRW-1], t2_ff};
   assign last_j  = j_ff == JW'(L - 1);
   assign is_term = (int'(j_ff) + int'(q_ff)) <= int'(p_ff);
   assign ind     = (kr_ff[0] <= x_ff) && (x_ff < kr_ff[1]);
   assign rc_last = (q_ff == 2'd0) ? 3'd2 : 3'd4;
   assign term    = (den_ff == '0) ? '0 : div_quot;

   // Clamp the level sum to 0..One.
   always_comb begin
      if (sum < 0) begin
         sat = '0;
      end else if (sum > $signed({{(PRW + 1 - VW){1'b0}}, One})) begin
         sat = One;
      end else begin
         sat = sum[VW-1:0];
      end
   end

   // Main sequencer.
   always_comb begin
      logic [VW-1:0] tail;
      logic          rotate;
      logic          advance;

      state_in      = state_ff;
      idx_in        = idx_ff;
      x_in          = x_ff;
      p_in          = p_ff;
      q_in          = q_ff;
      j_in          = j_ff;
      rc_in         = rc_ff;
      ph_in         = ph_ff;
      started_in    = started_ff;
      kr_in         = kr_ff;
      lv_in         = lv_ff;
      prod_in       = prod_ff;
      den_in        = den_ff;
      t1_in         = t1_ff;
      t2_in         = t2_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      div_start     = 1'b0;
      tail          = lv_ff[0];
      rotate        = 1'b0;
      advance       = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid && (req_tuser == REQ_EVAL)) begin
               idx_in = f_index;
               x_in   = f_x;
               p_in   = degree_ff;
               q_in   = 2'd0;
               j_in   = '0;
               ph_in  = 1'b0;
               if ((degree_ff > 2'(lci_ff > 5'd3 ? 2'd3 : lci_ff[1:0]))
                   && (lci_ff < 5'd3) || ({1'b0, degree_ff} > MaxDeg)) begin
                  status_in = ST_DEGREE;
                  lv_in[0]  = '0;
                  state_in  = S_DONE;
               end else if (f_index > lci_ff) begin
                  status_in = ST_INDEX;
                  lv_in[0]  = '0;
                  state_in  = S_DONE;
               end else begin
                  status_in = ST_OK;
                  state_in  = S_STEP;
               end
            end
         end
         S_STEP: begin
            rc_in = '0;
            if ((q_ff == 2'd0) ? (int'(j_ff) <= int'(p_ff)) : is_term) begin
               state_in = S_READ;
            end else begin
               rotate  = 1'b1;
               advance = 1'b1;
            end
         end
         S_READ: begin
            if (rc_ff != 3'd0) begin
               kr_in[rc_ff[1:0] - 2'd1] = ok_ff ? ram_rdata : '0;
            end
            rc_in = rc_ff + 3'd1;
            if (rc_ff == rc_last) begin
               state_in = (q_ff == 2'd0) ? S_LV0 : S_MUL;
            end
         end
         S_LV0: begin
            tail    = ind ? One : '0;
            rotate  = 1'b1;
            advance = 1'b1;
         end
         S_MUL: begin
            prod_in    = PRW'(num_sel) * PRW'($signed({1'b0, low_sel}));
            den_in     = den_sel;
            started_in = 1'b0;
            state_in   = S_DIV;
         end
         S_DIV: begin
            if (den_ff == '0 || (started_ff && div_done)) begin
               started_in = 1'b0;
               if (ph_ff) begin
                  t2_in    = term;
                  ph_in    = 1'b0;
                  state_in = S_SUM;
               end else begin
                  t1_in    = term;
                  ph_in    = 1'b1;
                  state_in = S_MUL;
               end
            end else if (!started_ff) begin
               div_start  = 1'b1;
               started_in = 1'b1;
            end
         end
         S_SUM: begin
            tail    = sat;
            rotate  = 1'b1;
            advance = 1'b1;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = lv_ff[0];
               rsp_status_in = status_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // Rotate the level values left by one; tail enters the last slot.
      if (rotate) begin
         for (int k = 0; k < L - 1; k++) begin
            lv_in[k] = lv_ff[k + 1];
         end
         lv_in[L-1] = tail;
      end

      // Step to the next position, level, or finish.
      if (advance) begin
         state_in = S_STEP;
         if (last_j) begin
            j_in = '0;
            if (q_ff == p_ff) begin
               state_in = S_DONE;
            end else begin
               q_in = q_ff + 2'd1;
            end
         end else begin
            j_in = j_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         started_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         started_ff   <= started_in;
      end
      idx_ff        <= idx_in;
      x_ff          <= x_in;
      p_ff          <= p_in;
      q_ff          <= q_in;
      j_ff          <= j_in;
      rc_ff         <= rc_in;
      ph_ff         <= ph_in;
      kr_ff         <= kr_in;
      lv_ff         <= lv_in;
      prod_ff       <= prod_in;
      den_ff        <= den_in;
      t1_ff         <= t1_in;
      t2_ff         <= t2_in;
      status_ff     <= status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_tready = state_ff == S_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSPW'({rsp_status_ff, rsp_value_ff});

   // The divider is only started while a term division is pending.
   a_div_start: assert property (@(posedge clock) disable iff (reset)
      div_start |-> (state_ff == S_DIV) && (den_ff != '0))
      else $error("divider started outside a term division");

   // A failed check always returns a zero value.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_status_ff != ST_OK) |-> (rsp_value_ff == '0))
      else $error("nonzero value with error status");

   // Values stay within 0..One.
   a_value_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_value_ff <= One))
      else $error("basis value above one");

   // Status is always a defined code.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_status_ff == ST_OK || rsp_status_ff == ST_INDEX
                      || rsp_status_ff == ST_DEGREE))
      else $error("undefined status code");
endmodule
`default_nettype wire
